FILE: hw/rtl/vrsl_pkg.sv
// Shared types and constants for the raster sync locator.
`timescale 1ns / 1ps

package vrsl_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int LINE_REG_W  = 12;
    localparam int FRAME_REG_W = 11;
    localparam int GAIN_W      = 24;
    localparam int GRAY_W      = 8;
    localparam int COL_CNT_W   = 11;
    localparam int ROW_CNT_W   = 12;
    localparam int SKIP_W      = 21;

    localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};
    localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};
    localparam int Y_SKIP_LIMIT = 10;

    // APB register map: index lives in paddr[4:2]
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_THRESH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLACK_LEVEL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_GAIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_MARK_EN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REALIGN_EN   = 3'd6;

    // Reset values
    localparam logic [LINE_REG_W-1:0]  RST_LINE_WIDTH   = 12'd1285;
    localparam logic [FRAME_REG_W-1:0] RST_FRAME_HEIGHT = 11'd730;
    localparam logic [SAMPLE_W-1:0]    RST_SYNC_THRESH  = 16'hF893;  // -1901
    localparam logic [SAMPLE_W-1:0]    RST_BLACK_LEVEL  = 16'hFBE7;  // -1049
    localparam logic [GAIN_W-1:0]      RST_PIXEL_GAIN   = 24'd4637;
    localparam logic                   RST_SYNC_MARK_EN = 1'b0;
    localparam logic                   RST_REALIGN_EN   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic advance;  // stage-1 pixel moves to the output register
        logic flush;    // frame-end pixel retires into the hold registers
        logic scan;     // argmax scan / clear step at scan index
        logic mul;      // register y_offset * width
        logic report;   // load frame-end result, arm skip
    } vrsl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic s1_valid;
        logic out_room;
        logic ends_frame;
        logic skip_active;
    } vrsl_stat_t;

endpackage

FILE: hw/rtl/video_raster_sync_locator.sv
// Raster sync locator: turns Q1.15 video samples into gray pixels tagged with column
// and row, counts below-sync samples per column and per row, and at the end of each
// frame reports the first column and row with the most sync samples. In streaming
// operation one sample is taken per clock; each pixel passes a stage register and a
// result register before it is offered, and an output stall holds the input once both
// registers hold a pixel. Samples dropped by auto sync are also taken one per clock
// and give no result. The last pixel of a frame stops input, longer while the output
// stalls: the histograms sit in single-write-port RAMs that are scanned and cleared one
// entry per cycle, then the skip length is formed by a registered multiply and an add.
// After reset the same sweep clears both RAMs with no input taken; register writes are
// taken at any time.
`timescale 1ns / 1ps

module video_raster_sync_locator #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vrsl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vrsl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vrsl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vrsl_pkg::SAMPLE_W-1:0]       s_sample,
    // pixel output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [CW-1:0]                       m_column,
    output logic [RW-1:0]                       m_row,
    output logic [vrsl_pkg::GRAY_W-1:0]         m_gray,
    output logic                                m_sync_marked,
    output logic                                m_frame_done,
    output logic [CW-1:0]                       m_x_offset,
    output logic [RW-1:0]                       m_y_offset,
    output logic                                m_skip_armed
);

    localparam int SCAN_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SCW = $clog2(SCAN_LEN);
    localparam int DW  = vrsl_pkg::APB_DATA_W;

    // Configuration registers
    logic [vrsl_pkg::LINE_REG_W-1:0]  line_width_reg, line_width_next;
    logic [vrsl_pkg::FRAME_REG_W-1:0] frame_height_reg, frame_height_next;
    logic [vrsl_pkg::SAMPLE_W-1:0]    sync_thresh_reg, sync_thresh_next;
    logic [vrsl_pkg::SAMPLE_W-1:0]    black_level_reg, black_level_next;
    logic [vrsl_pkg::GAIN_W-1:0]      pixel_gain_reg, pixel_gain_next;
    logic                             sync_mark_en_reg, sync_mark_en_next;
    logic                             realign_en_reg, realign_en_next;

    logic                              wr_en;
    logic [vrsl_pkg::REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[vrsl_pkg::APB_ADDR_W-1:2];

    // Register writes
    always_comb begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        sync_thresh_next  = sync_thresh_reg;
        black_level_next  = black_level_reg;
        pixel_gain_next   = pixel_gain_reg;
        sync_mark_en_next = sync_mark_en_reg;
        realign_en_next   = realign_en_reg;
        if (wr_en) begin
            case (reg_idx)
                vrsl_pkg::REG_LINE_WIDTH:
                    line_width_next = pwdata[vrsl_pkg::LINE_REG_W-1:0];
                vrsl_pkg::REG_FRAME_HEIGHT:
                    frame_height_next = pwdata[vrsl_pkg::FRAME_REG_W-1:0];
                vrsl_pkg::REG_SYNC_THRESH:
                    sync_thresh_next = pwdata[vrsl_pkg::SAMPLE_W-1:0];
                vrsl_pkg::REG_BLACK_LEVEL:
                    black_level_next = pwdata[vrsl_pkg::SAMPLE_W-1:0];
                vrsl_pkg::REG_PIXEL_GAIN:
                    pixel_gain_next = pwdata[vrsl_pkg::GAIN_W-1:0];
                vrsl_pkg::REG_SYNC_MARK_EN:
                    sync_mark_en_next = pwdata[0];
                vrsl_pkg::REG_REALIGN_EN:
                    realign_en_next = pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= vrsl_pkg::RST_LINE_WIDTH;
            frame_height_reg <= vrsl_pkg::RST_FRAME_HEIGHT;
            sync_thresh_reg  <= vrsl_pkg::RST_SYNC_THRESH;
            black_level_reg  <= vrsl_pkg::RST_BLACK_LEVEL;
            pixel_gain_reg   <= vrsl_pkg::RST_PIXEL_GAIN;
            sync_mark_en_reg <= vrsl_pkg::RST_SYNC_MARK_EN;
            realign_en_reg   <= vrsl_pkg::RST_REALIGN_EN;
        end else begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            sync_thresh_reg  <= sync_thresh_next;
            black_level_reg  <= black_level_next;
            pixel_gain_reg   <= pixel_gain_next;
            sync_mark_en_reg <= sync_mark_en_next;
            realign_en_reg   <= realign_en_next;
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            vrsl_pkg::REG_LINE_WIDTH:   prdata = DW'(line_width_reg);
            vrsl_pkg::REG_FRAME_HEIGHT: prdata = DW'(frame_height_reg);
            vrsl_pkg::REG_SYNC_THRESH:  prdata = DW'(sync_thresh_reg);
            vrsl_pkg::REG_BLACK_LEVEL:  prdata = DW'(black_level_reg);
            vrsl_pkg::REG_PIXEL_GAIN:   prdata = DW'(pixel_gain_reg);
            vrsl_pkg::REG_SYNC_MARK_EN: prdata = DW'(sync_mark_en_reg);
            vrsl_pkg::REG_REALIGN_EN:   prdata = DW'(realign_en_reg);
            default:                    prdata = '0;
        endcase
    end

    // Controller and datapath
    vrsl_pkg::vrsl_cmd_t  cmd;
    vrsl_pkg::vrsl_stat_t stat;
    logic [SCW-1:0]       scan_idx;

    vrsl_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    vrsl_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .scan_idx      (scan_idx),
        .stat          (stat),
        .line_width    (line_width_reg),
        .frame_height  (frame_height_reg),
        .sync_thresh   (sync_thresh_reg),
        .black_level   (black_level_reg),
        .pixel_gain    (pixel_gain_reg),
        .sync_mark_en  (sync_mark_en_reg),
        .realign_en    (realign_en_reg),
        .s_sample      (s_sample),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_gray        (m_gray),
        .m_sync_marked (m_sync_marked),
        .m_frame_done  (m_frame_done),
        .m_x_offset    (m_x_offset),
        .m_y_offset    (m_y_offset),
        .m_skip_armed  (m_skip_armed)
    );

endmodule

FILE: hw/rtl/vrsl_ram.sv
// Generic simple dual-port RAM, read-first, registered read data.
`timescale 1ns / 1ps

module vrsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/vrsl_hist.sv
// Sync histogram: saturating increment, argmax scan and clearing sweep.
`timescale 1ns / 1ps

module vrsl_hist #(
    parameter int DEPTH = 2048,
    parameter int CNT_W = 11,
    parameter int IDX_W = 11,
    parameter int LIM_W = 12,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             inc_en,
    input  logic             scan_en,
    input  logic [IDX_W-1:0] scan_idx,
    input  logic [LIM_W-1:0] limit,
    output logic [AW-1:0]    best_idx
);

    localparam int CMP_W = ((IDX_W > LIM_W) ? IDX_W : LIM_W) + 1;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [CNT_W-1:0] rd_data;

    logic [AW-1:0]    addr_reg, addr_next;
    logic             last_valid_reg, last_valid_next;
    logic [AW-1:0]    last_addr_reg, last_addr_next;
    logic [CNT_W-1:0] last_data_reg, last_data_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] inc_cnt;
    logic             scan_in_range;
    logic             take;

    // Read-modify-write: forward the latest write when it hit the same entry
    assign cur_cnt = (last_valid_reg && (last_addr_reg == addr_reg)) ? last_data_reg : rd_data;
    assign inc_cnt = (cur_cnt == {CNT_W{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;

    // Port muxing between scan sweep and pixel updates
    assign scan_in_range = CMP_W'(scan_idx) < CMP_W'(DEPTH);
    assign ram_we    = scan_en ? scan_in_range : inc_en;
    assign ram_waddr = scan_en ? scan_idx[AW-1:0] : addr_reg;
    assign ram_wdata = scan_en ? '0 : inc_cnt;
    assign ram_re    = scan_en | rd_en;
    assign ram_raddr = scan_en ? scan_idx[AW-1:0] : rd_addr;

    vrsl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    // First-maximum compare over entries below the limit
    assign take = cmp_valid_reg && (CMP_W'(cmp_idx_reg) < CMP_W'(limit)) &&
                  ((cmp_idx_reg == '0) || (rd_data > best_cnt_reg));

    always_comb begin
        addr_next       = rd_en ? rd_addr : addr_reg;
        last_valid_next = ram_we ? 1'b1 : last_valid_reg;
        last_addr_next  = ram_we ? ram_waddr : last_addr_reg;
        last_data_next  = ram_we ? ram_wdata : last_data_reg;
        cmp_valid_next  = scan_en;
        cmp_idx_next    = scan_en ? scan_idx : cmp_idx_reg;
        best_cnt_next   = take ? rd_data : best_cnt_reg;
        best_idx_next   = take ? cmp_idx_reg[AW-1:0] : best_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_valid_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
        end else begin
            last_valid_reg <= last_valid_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        last_addr_reg <= last_addr_next;
        last_data_reg <= last_data_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_cnt_reg  <= best_cnt_next;
        best_idx_reg  <= best_idx_next;
    end

    assign best_idx = best_idx_reg;

endmodule

FILE: hw/rtl/vrsl_dp.sv
// Datapath: raster position, gray scaling, histograms, skip counter, result register.
`timescale 1ns / 1ps

module vrsl_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int RW  = $clog2(MAX_HEIGHT),
    localparam int SCAN_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
    localparam int SCW = $clog2(SCAN_LEN)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vrsl_pkg::vrsl_cmd_t                  cmd,
    input  logic [SCW-1:0]                       scan_idx,
    output vrsl_pkg::vrsl_stat_t                 stat,
    input  logic [vrsl_pkg::LINE_REG_W-1:0]      line_width,
    input  logic [vrsl_pkg::FRAME_REG_W-1:0]     frame_height,
    input  logic [vrsl_pkg::SAMPLE_W-1:0]        sync_thresh,
    input  logic [vrsl_pkg::SAMPLE_W-1:0]        black_level,
    input  logic [vrsl_pkg::GAIN_W-1:0]          pixel_gain,
    input  logic                                 sync_mark_en,
    input  logic                                 realign_en,
    input  logic [vrsl_pkg::SAMPLE_W-1:0]        s_sample,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [CW-1:0]                        m_column,
    output logic [RW-1:0]                        m_row,
    output logic [vrsl_pkg::GRAY_W-1:0]          m_gray,
    output logic                                 m_sync_marked,
    output logic                                 m_frame_done,
    output logic [CW-1:0]                        m_x_offset,
    output logic [RW-1:0]                        m_y_offset,
    output logic                                 m_skip_armed
);

    localparam int WW   = CW + 1;
    localparam int HW   = RW + 1;
    localparam int LWX  = (vrsl_pkg::LINE_REG_W > WW) ? vrsl_pkg::LINE_REG_W : WW;
    localparam int HWX  = (vrsl_pkg::FRAME_REG_W > HW) ? vrsl_pkg::FRAME_REG_W : HW;
    localparam int PW   = RW + WW;
    localparam int EXTW = ((PW + 1) > vrsl_pkg::SKIP_W) ? (PW + 1) : vrsl_pkg::SKIP_W;
    localparam int SW   = vrsl_pkg::SAMPLE_W;
    localparam int MW   = vrsl_pkg::SAMPLE_W + vrsl_pkg::GAIN_W;

    // Geometry in use, clamped to 1..MAX
    logic [LWX-1:0] lw_ext, w_full;
    logic [HWX-1:0] fh_ext, h_full;
    logic [WW-1:0]  w_use;
    logic [HW-1:0]  h_use;

    assign lw_ext = LWX'(line_width);
    assign fh_ext = HWX'(frame_height);
    assign w_full = (lw_ext == '0) ? LWX'(1) :
                    (lw_ext > LWX'(MAX_WIDTH)) ? LWX'(MAX_WIDTH) : lw_ext;
    assign h_full = (fh_ext == '0) ? HWX'(1) :
                    (fh_ext > HWX'(MAX_HEIGHT)) ? HWX'(MAX_HEIGHT) : fh_ext;
    assign w_use = w_full[WW-1:0];
    assign h_use = h_full[HW-1:0];

    // Registers
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [vrsl_pkg::SKIP_W-1:0] skip_reg, skip_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [SW-1:0] s1_sample_reg, s1_sample_next;
    logic [CW-1:0] s1_col_reg, s1_col_next;
    logic [RW-1:0] s1_row_reg, s1_row_next;
    logic          s1_below_reg, s1_below_next;

    logic [CW-1:0]                hold_col_reg, hold_col_next;
    logic [RW-1:0]                hold_row_reg, hold_row_next;
    logic [vrsl_pkg::GRAY_W-1:0]  hold_gray_reg, hold_gray_next;
    logic                         hold_sync_reg, hold_sync_next;

    logic [PW-1:0] prod_reg, prod_next;

    logic                         m_valid_reg, m_valid_next;
    logic [CW-1:0]                m_column_reg, m_column_next;
    logic [RW-1:0]                m_row_reg, m_row_next;
    logic [vrsl_pkg::GRAY_W-1:0]  m_gray_reg, m_gray_next;
    logic                         m_sync_reg, m_sync_next;
    logic                         m_done_reg, m_done_next;
    logic [CW-1:0]                m_xo_reg, m_xo_next;
    logic [RW-1:0]                m_yo_reg, m_yo_next;
    logic                         m_armed_reg, m_armed_next;

    // Position advance for the pixel at the current position
    logic          skip_active;
    logic          take_pixel;
    logic          retire;
    logic [WW-1:0] col_inc;
    logic          col_wrap;
    logic [HW-1:0] row_after;
    logic          ends_frame;
    logic          below;

    assign skip_active = (skip_reg != '0);
    assign take_pixel  = cmd.accept && !skip_active;
    assign retire      = cmd.advance || cmd.flush;
    assign col_inc     = WW'(col_pos_reg) + WW'(1);
    assign col_wrap    = (col_inc >= w_use);
    assign row_after   = col_wrap ? (HW'(row_pos_reg) + HW'(1)) : HW'(row_pos_reg);
    assign ends_frame  = (row_after >= h_use);
    assign below       = $signed(s_sample) < $signed(sync_thresh);

    // Gray scaling on the stage-1 sample
    logic signed [SW:0]          diff;
    logic                        diff_pos;
    logic [MW-1:0]               prod_gray;
    logic [vrsl_pkg::GAIN_W-1:0] scaled;
    logic [vrsl_pkg::GRAY_W-1:0] gray_calc;

    assign diff      = $signed({s1_sample_reg[SW-1], s1_sample_reg}) -
                       $signed({black_level[SW-1], black_level});
    assign diff_pos  = !diff[SW] && (diff != '0);
    assign prod_gray = MW'(diff[SW-1:0]) * MW'(pixel_gain);
    assign scaled    = prod_gray[MW-1:SW];
    assign gray_calc = !diff_pos ? '0 :
                       (|scaled[vrsl_pkg::GAIN_W-1:vrsl_pkg::GRAY_W]) ? vrsl_pkg::GRAY_MAX :
                       scaled[vrsl_pkg::GRAY_W-1:0];

    // Histograms
    logic [CW-1:0] x_best;
    logic [RW-1:0] y_best;

    vrsl_hist #(
        .DEPTH (MAX_WIDTH),
        .CNT_W (vrsl_pkg::COL_CNT_W),
        .IDX_W (SCW),
        .LIM_W (WW)
    ) u_col_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (take_pixel),
        .rd_addr  (col_pos_reg),
        .inc_en   (retire && s1_below_reg),
        .scan_en  (cmd.scan),
        .scan_idx (scan_idx),
        .limit    (w_use),
        .best_idx (x_best)
    );

    vrsl_hist #(
        .DEPTH (MAX_HEIGHT),
        .CNT_W (vrsl_pkg::ROW_CNT_W),
        .IDX_W (SCW),
        .LIM_W (HW)
    ) u_row_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (take_pixel),
        .rd_addr  (row_pos_reg),
        .inc_en   (retire && s1_below_reg),
        .scan_en  (cmd.scan),
        .scan_idx (scan_idx),
        .limit    (h_use),
        .best_idx (y_best)
    );

    // Skip length: x + y * width, saturated
    logic                        armed;
    logic [EXTW-1:0]             skip_sum;
    logic [vrsl_pkg::SKIP_W-1:0] skip_val;

    assign armed    = realign_en && (y_best > RW'(vrsl_pkg::Y_SKIP_LIMIT));
    assign skip_sum = EXTW'(x_best) + EXTW'(prod_reg);
    assign skip_val = (skip_sum > EXTW'(vrsl_pkg::SKIP_MAX)) ? vrsl_pkg::SKIP_MAX :
                      skip_sum[vrsl_pkg::SKIP_W-1:0];

    // Next-state logic
    always_comb begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        skip_next      = skip_reg;
        s1_valid_next  = s1_valid_reg;
        s1_sample_next = s1_sample_reg;
        s1_col_next    = s1_col_reg;
        s1_row_next    = s1_row_reg;
        s1_below_next  = s1_below_reg;
        hold_col_next  = hold_col_reg;
        hold_row_next  = hold_row_reg;
        hold_gray_next = hold_gray_reg;
        hold_sync_next = hold_sync_reg;
        prod_next      = prod_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        m_column_next  = m_column_reg;
        m_row_next     = m_row_reg;
        m_gray_next    = m_gray_reg;
        m_sync_next    = m_sync_reg;
        m_done_next    = m_done_reg;
        m_xo_next      = m_xo_reg;
        m_yo_next      = m_yo_reg;
        m_armed_next   = m_armed_reg;

        // dropped sample only counts down
        if (cmd.accept && skip_active) begin
            skip_next = skip_reg - 1'b1;
        end

        // stage 1 leaves, then a new pixel may enter
        if (retire) begin
            s1_valid_next = 1'b0;
        end
        if (take_pixel) begin
            s1_valid_next  = 1'b1;
            s1_sample_next = s_sample;
            s1_col_next    = col_pos_reg;
            s1_row_next    = row_pos_reg;
            s1_below_next  = below;
            if (ends_frame) begin
                col_pos_next = '0;
                row_pos_next = '0;
            end else begin
                col_pos_next = col_wrap ? '0 : col_inc[CW-1:0];
                row_pos_next = row_after[RW-1:0];
            end
        end

        // frame-end pixel waits in hold registers during the scan
        if (cmd.flush) begin
            hold_col_next  = s1_col_reg;
            hold_row_next  = s1_row_reg;
            hold_gray_next = gray_calc;
            hold_sync_next = s1_below_reg && sync_mark_en;
        end

        if (cmd.mul) begin
            prod_next = PW'(y_best) * PW'(w_use);
        end

        // result register loads
        if (cmd.advance) begin
            m_valid_next  = 1'b1;
            m_column_next = s1_col_reg;
            m_row_next    = s1_row_reg;
            m_gray_next   = gray_calc;
            m_sync_next   = s1_below_reg && sync_mark_en;
            m_done_next   = 1'b0;
            m_xo_next     = '0;
            m_yo_next     = '0;
            m_armed_next  = 1'b0;
        end else if (cmd.report) begin
            m_valid_next  = 1'b1;
            m_column_next = hold_col_reg;
            m_row_next    = hold_row_reg;
            m_gray_next   = hold_gray_reg;
            m_sync_next   = hold_sync_reg;
            m_done_next   = 1'b1;
            m_xo_next     = x_best;
            m_yo_next     = y_best;
            m_armed_next  = armed;
            if (armed) begin
                skip_next = skip_val;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            skip_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            skip_reg     <= skip_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        s1_sample_reg <= s1_sample_next;
        s1_col_reg    <= s1_col_next;
        s1_row_reg    <= s1_row_next;
        s1_below_reg  <= s1_below_next;
        hold_col_reg  <= hold_col_next;
        hold_row_reg  <= hold_row_next;
        hold_gray_reg <= hold_gray_next;
        hold_sync_reg <= hold_sync_next;
        prod_reg      <= prod_next;
        m_column_reg  <= m_column_next;
        m_row_reg     <= m_row_next;
        m_gray_reg    <= m_gray_next;
        m_sync_reg    <= m_sync_next;
        m_done_reg    <= m_done_next;
        m_xo_reg      <= m_xo_next;
        m_yo_reg      <= m_yo_next;
        m_armed_reg   <= m_armed_next;
    end

    // Status
    assign stat.s1_valid    = s1_valid_reg;
    assign stat.out_room    = !m_valid_reg || m_ready;
    assign stat.ends_frame  = ends_frame;
    assign stat.skip_active = skip_active;

    assign m_valid       = m_valid_reg;
    assign m_column      = m_column_reg;
    assign m_row         = m_row_reg;
    assign m_gray        = m_gray_reg;
    assign m_sync_marked = m_sync_reg;
    assign m_frame_done  = m_done_reg;
    assign m_x_offset    = m_xo_reg;
    assign m_y_offset    = m_yo_reg;
    assign m_skip_armed  = m_armed_reg;

endmodule

FILE: hw/rtl/vrsl_ctrl.sv
// Controller: input handshake, frame-end scan sequencing and reset clearing sweep.
`timescale 1ns / 1ps

module vrsl_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 1024,
    localparam int SCAN_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
    localparam int SCW = $clog2(SCAN_LEN)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vrsl_pkg::vrsl_stat_t stat,
    output vrsl_pkg::vrsl_cmd_t  cmd,
    output logic [SCW-1:0]       scan_idx
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FLUSH,
        ST_SCAN,
        ST_TAIL,
        ST_MUL,
        ST_REPORT
    } state_t;

    state_t         state_reg, state_next;
    logic [SCW-1:0] idx_reg, idx_next;
    logic           idx_last;

    assign idx_last = (idx_reg == SCW'(SCAN_LEN - 1));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            // sweep both histograms to zero after reset
            ST_CLEAR: begin
                cmd.scan = 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // streaming: one request per cycle while the output side drains
            ST_RUN: begin
                s_ready     = !stat.s1_valid || stat.out_room;
                cmd.accept  = s_valid && s_ready;
                cmd.advance = stat.s1_valid && stat.out_room;
                if (cmd.accept && stat.ends_frame && !stat.skip_active) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush  = 1'b1;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            // argmax and clear, one entry of each histogram per cycle
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_TAIL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TAIL: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (stat.out_room) begin
                    cmd.report = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign scan_idx = idx_reg;

endmodule

FILE: bench/video_raster_sync_locator_tb.sv
// Self-checking testbench for the raster sync locator: directed table, then random frames.
`timescale 1ns / 1ps

module video_raster_sync_locator_tb;

    localparam int MAX_W = 2048;
    localparam int MAX_H = 1024;
    // frame-end sweep plus skip math, with margin
    localparam int SETTLE_CYCLES = MAX_W + 64;
    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_TARGET = 1900;
    localparam logic [vrsl_pkg::COL_CNT_W-1:0] COL_HIT_MAX = '1;
    localparam logic [vrsl_pkg::ROW_CNT_W-1:0] ROW_HIT_MAX = '1;

    typedef struct packed {
        logic [10:0] column;
        logic [9:0]  row;
        logic [7:0]  gray;
        logic        sync_marked;
        logic        frame_done;
        logic [10:0] x_offset;
        logic [9:0]  y_offset;
        logic        skip_armed;
    } pixel_t;

    // predicted pixel plus an optional hand-computed gray (-1 when absent)
    typedef struct {
        pixel_t px;
        int     pin;
    } pending_pixel_t;

    typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [vrsl_pkg::REG_IDX_W-1:0]   idx;
        logic [31:0]                      value;
        int                               pin;
    } dir_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [vrsl_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [vrsl_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [vrsl_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [vrsl_pkg::SAMPLE_W-1:0]    s_sample = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [10:0]                      m_column;
    logic [9:0]                       m_row;
    logic [vrsl_pkg::GRAY_W-1:0]      m_gray;
    logic                             m_sync_marked;
    logic                             m_frame_done;
    logic [10:0]                      m_x_offset;
    logic [9:0]                       m_y_offset;
    logic                             m_skip_armed;

    // register mirror
    logic [vrsl_pkg::LINE_REG_W-1:0]      cfg_width = vrsl_pkg::RST_LINE_WIDTH;
    logic [vrsl_pkg::FRAME_REG_W-1:0]     cfg_height = vrsl_pkg::RST_FRAME_HEIGHT;
    logic signed [vrsl_pkg::SAMPLE_W-1:0] cfg_sync = vrsl_pkg::RST_SYNC_THRESH;
    logic signed [vrsl_pkg::SAMPLE_W-1:0] cfg_black = vrsl_pkg::RST_BLACK_LEVEL;
    logic [vrsl_pkg::GAIN_W-1:0]          cfg_gain = vrsl_pkg::RST_PIXEL_GAIN;
    logic                                 cfg_live = vrsl_pkg::RST_SYNC_MARK_EN;
    logic                                 cfg_auto = vrsl_pkg::RST_REALIGN_EN;

    // raster and histogram state
    logic [vrsl_pkg::COL_CNT_W-1:0] col_hits [MAX_W];
    logic [vrsl_pkg::ROW_CNT_W-1:0] row_hits [MAX_H];
    int col_pos = 0;
    int row_pos = 0;
    int skip_left = 0;

    pending_pixel_t pending_pixels [$];
    int items_taken = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int pinned_gray = -1;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    video_raster_sync_locator #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column     (m_column),
        .m_row        (m_row),
        .m_gray       (m_gray),
        .m_sync_marked(m_sync_marked),
        .m_frame_done (m_frame_done),
        .m_x_offset   (m_x_offset),
        .m_y_offset   (m_y_offset),
        .m_skip_armed (m_skip_armed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_hits();
        foreach (col_hits[i]) col_hits[i] = '0;
        foreach (row_hits[i]) row_hits[i] = '0;
    endfunction

    function automatic int width_in_use();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return int'(cfg_width);
    endfunction

    function automatic int height_in_use();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_H) return MAX_H;
        return int'(cfg_height);
    endfunction

    // One sample through the raster: returns 1 when it yields a pixel
    function automatic bit raster_step(input logic signed [vrsl_pkg::SAMPLE_W-1:0] smp,
                                       output pixel_t px);
        int w;
        int h;
        int xo;
        int yo;
        longint diff;
        longint g;
        longint span;
        bit below;
        px = '0;
        w = width_in_use();
        h = height_in_use();
        if (skip_left != 0) begin
            skip_left--;
            return 1'b0;
        end

        below = smp < cfg_sync;
        if (below) begin
            if (col_hits[col_pos] != COL_HIT_MAX) col_hits[col_pos]++;
            if (row_hits[row_pos] != ROW_HIT_MAX) row_hits[row_pos]++;
        end

        px.column = col_pos[10:0];
        px.row = row_pos[9:0];
        diff = longint'(smp) - longint'(cfg_black);
        g = (diff <= 0) ? 0 : (diff * longint'(cfg_gain)) >>> 16;
        px.gray = (g > vrsl_pkg::GRAY_MAX) ? vrsl_pkg::GRAY_MAX : g[7:0];
        px.sync_marked = below && cfg_live;

        // advance; a position beyond a shrunk geometry wraps on this step
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
            xo = 0;
            yo = 0;
            for (int i = 1; i < w; i++) if (col_hits[i] > col_hits[xo]) xo = i;
            for (int i = 1; i < h; i++) if (row_hits[i] > row_hits[yo]) yo = i;
            clear_hits();
            if (cfg_auto && yo > vrsl_pkg::Y_SKIP_LIMIT) begin
                span = longint'(xo) + longint'(yo) * longint'(w);
                skip_left = (span > vrsl_pkg::SKIP_MAX) ? int'(vrsl_pkg::SKIP_MAX) : int'(span);
                px.skip_armed = 1'b1;
            end
            px.frame_done = 1'b1;
            px.x_offset = xo[10:0];
            px.y_offset = yo[9:0];
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Bus monitor: register mirror, prediction, result check, stall watchdog
    always @(posedge aclk) begin : monitor
        pixel_t px;
        pending_pixel_t head;
        bit took_in;
        bit took_out;
        took_in = s_valid && s_ready;
        took_out = m_valid && m_ready;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    vrsl_pkg::REG_LINE_WIDTH:   cfg_width = pwdata[vrsl_pkg::LINE_REG_W-1:0];
                    vrsl_pkg::REG_FRAME_HEIGHT: cfg_height = pwdata[vrsl_pkg::FRAME_REG_W-1:0];
                    vrsl_pkg::REG_SYNC_THRESH:  cfg_sync = pwdata[vrsl_pkg::SAMPLE_W-1:0];
                    vrsl_pkg::REG_BLACK_LEVEL:  cfg_black = pwdata[vrsl_pkg::SAMPLE_W-1:0];
                    vrsl_pkg::REG_PIXEL_GAIN:   cfg_gain = pwdata[vrsl_pkg::GAIN_W-1:0];
                    vrsl_pkg::REG_SYNC_MARK_EN: cfg_live = pwdata[0];
                    vrsl_pkg::REG_REALIGN_EN:   cfg_auto = pwdata[0];
                    default: ;
                endcase
            end

            if (took_in) begin
                items_taken++;
                if (raster_step(s_sample, px))
                    pending_pixels.push_back('{px: px, pin: pinned_gray});
            end

            if (took_out) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel with no request pending: column %0d row %0d",
                           m_column, m_row);
                    mismatches++;
                end else begin
                    head = pending_pixels.pop_front();
                    check_field("column", head.px.column, m_column);
                    check_field("row", head.px.row, m_row);
                    check_field("gray", head.px.gray, m_gray);
                    check_field("sync_marked", head.px.sync_marked, m_sync_marked);
                    check_field("frame_done", head.px.frame_done, m_frame_done);
                    check_field("x_offset", head.px.x_offset, m_x_offset);
                    check_field("y_offset", head.px.y_offset, m_y_offset);
                    check_field("skip_armed", head.px.skip_armed, m_skip_armed);
                    if (head.pin >= 0) check_field("gray (hand value)", head.pin, m_gray);
                end
            end

            if ((s_valid || pending_pixels.size() != 0) && !took_in && !took_out)
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("video_raster_sync_locator_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic push_sample(input logic [vrsl_pkg::SAMPLE_W-1:0] v, input int pin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pinned_gray = pin;
        s_valid <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic reg_write(input logic [vrsl_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop valid, drain every pending pixel, then let a frame-end sweep finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [vrsl_pkg::SAMPLE_W-1:0] level_between(input int lo,
                                                                    input int hi);
        return vrsl_pkg::SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Mostly a sync pattern at column xc and row yc, some plain noise
    function automatic logic [vrsl_pkg::SAMPLE_W-1:0] video_sample(input int xc,
                                                                   input int yc);
        int lvl;
        lvl = cfg_sync;
        if ($urandom_range(0, 99) < 20) return vrsl_pkg::SAMPLE_W'($urandom);
        if ((col_pos == xc || row_pos == yc) && lvl > -32768)
            return level_between(-32768, lvl - 1);
        return level_between(lvl, 32767);
    endfunction

    task automatic random_setup();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) reg_write(vrsl_pkg::REG_LINE_WIDTH, $urandom_range(1, 12));
        else if (r < 80) reg_write(vrsl_pkg::REG_LINE_WIDTH, 0);
        else if (r < 88) reg_write(vrsl_pkg::REG_LINE_WIDTH, 4095);
        else reg_write(vrsl_pkg::REG_LINE_WIDTH, $urandom_range(13, 4095));

        r = $urandom_range(0, 99);
        if (r < 55) reg_write(vrsl_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 16));
        else if (r < 85) reg_write(vrsl_pkg::REG_FRAME_HEIGHT, $urandom_range(12, 16));
        else if (r < 90) reg_write(vrsl_pkg::REG_FRAME_HEIGHT, 0);
        else if (r < 94) reg_write(vrsl_pkg::REG_FRAME_HEIGHT, 2047);
        else reg_write(vrsl_pkg::REG_FRAME_HEIGHT, $urandom_range(17, 2047));

        if ($urandom_range(0, 99) < 30)
            reg_write(vrsl_pkg::REG_SYNC_THRESH, 32'($urandom) & 32'hFFFF);
        else
            reg_write(vrsl_pkg::REG_SYNC_THRESH, 32'(level_between(-12000, 2000)));

        if ($urandom_range(0, 99) < 30)
            reg_write(vrsl_pkg::REG_BLACK_LEVEL, 32'($urandom) & 32'hFFFF);
        else
            reg_write(vrsl_pkg::REG_BLACK_LEVEL, 32'(level_between(-8000, 4000)));

        r = $urandom_range(0, 99);
        if (r < 10) reg_write(vrsl_pkg::REG_PIXEL_GAIN, 0);
        else if (r < 20) reg_write(vrsl_pkg::REG_PIXEL_GAIN, 32'hFF_FFFF);
        else if (r < 40) reg_write(vrsl_pkg::REG_PIXEL_GAIN, 32'($urandom) & 32'hFF_FFFF);
        else reg_write(vrsl_pkg::REG_PIXEL_GAIN, $urandom_range(500, 20000));

        reg_write(vrsl_pkg::REG_SYNC_MARK_EN, $urandom_range(0, 1));
        reg_write(vrsl_pkg::REG_REALIGN_EN, ($urandom_range(0, 99) < 80) ? 1 : 0);
    endtask

    function automatic dir_row_t wr(input logic [vrsl_pkg::REG_IDX_W-1:0] idx,
                                    input logic [31:0] val);
        return '{kind: ROW_WRITE, idx: idx, value: val, pin: -1};
    endfunction

    function automatic dir_row_t smp(input logic [vrsl_pkg::SAMPLE_W-1:0] v, input int pin);
        return '{kind: ROW_SAMPLE, idx: '0, value: 32'(v), pin: pin};
    endfunction

    initial begin : stimulus
        dir_row_t script [$];
        bit after_samples;
        int phase;
        int xc;
        int yc;
        int h;
        clear_hits();

        // reset values first, then level and gain extremes, then geometry corners
        script = '{
            smp(16'h8000, 0), smp(16'h7FFF, 255), smp(-16'sd1049, 0), smp(-16'sd1048, 0),
            smp(-16'sd1901, 0), smp(-16'sd1902, 0),
            wr(vrsl_pkg::REG_SYNC_MARK_EN, 1),
            smp(-16'sd1902, 0), smp(16'h0000, -1),
            wr(vrsl_pkg::REG_PIXEL_GAIN, 0),
            smp(16'h7FFF, 0),
            wr(vrsl_pkg::REG_PIXEL_GAIN, 32'hFF_FFFF),
            smp(-16'sd1048, 255),
            wr(vrsl_pkg::REG_BLACK_LEVEL, 32'h7FFF),
            smp(16'h7FFF, 0),
            wr(vrsl_pkg::REG_BLACK_LEVEL, 32'h8000),
            smp(16'h8000, 0), smp(16'h8001, 255),
            wr(vrsl_pkg::REG_SYNC_THRESH, 32'h8000),
            smp(16'h8000, 0),
            wr(vrsl_pkg::REG_SYNC_THRESH, 32'h7FFF),
            smp(16'h7FFE, 255), smp(16'h7FFF, 255),
            // width beyond the maximum, then a shrink that closes the frame
            wr(vrsl_pkg::REG_LINE_WIDTH, 4095), wr(vrsl_pkg::REG_FRAME_HEIGHT, 1),
            smp(16'h5A5A, -1),
            wr(vrsl_pkg::REG_LINE_WIDTH, 4),
            smp(16'h8000, 0),
            // zero geometry: every sample is a frame
            wr(vrsl_pkg::REG_REALIGN_EN, 0), wr(vrsl_pkg::REG_LINE_WIDTH, 0),
            wr(vrsl_pkg::REG_FRAME_HEIGHT, 0),
            smp(16'h8000, 0), smp(16'h0000, -1),
            // height beyond the maximum, then a row shrink
            wr(vrsl_pkg::REG_LINE_WIDTH, 1), wr(vrsl_pkg::REG_FRAME_HEIGHT, 2047),
            smp(16'hA5A5, -1), smp(16'h3C3C, -1), smp(16'hC3C3, -1),
            wr(vrsl_pkg::REG_FRAME_HEIGHT, 2),
            smp(16'h1234, -1)
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        after_samples = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                if (after_samples) wait_idle();
                after_samples = 1'b0;
                reg_write(script[i].idx, script[i].value);
            end else begin
                push_sample(script[i].value[vrsl_pkg::SAMPLE_W-1:0], script[i].pin);
                after_samples = 1'b1;
            end
        end

        // random phases: new settings and idling pattern each time
        phase = 0;
        while (items_taken < ITEM_TARGET) begin
            wait_idle();
            case (phase % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 66;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 66;
                end
                default: begin
                    tx_idle_pct = 20;
                    rx_stall_pct = 20;
                end
            endcase
            random_setup();
            h = height_in_use();
            xc = $urandom_range(0, width_in_use() - 1);
            if (h > vrsl_pkg::Y_SKIP_LIMIT + 1 && $urandom_range(0, 1) == 1)
                yc = $urandom_range(vrsl_pkg::Y_SKIP_LIMIT + 1, h - 1);
            else
                yc = $urandom_range(0, h - 1);
            repeat ($urandom_range(10, 120)) push_sample(video_sample(xc, yc), -1);
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("video_raster_sync_locator_tb: done, clean");
        else
            $display("video_raster_sync_locator_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/vrsl_pkg.sv
hw/rtl/vrsl_ram.sv
hw/rtl/vrsl_hist.sv
hw/rtl/vrsl_dp.sv
hw/rtl/vrsl_ctrl.sv
hw/rtl/video_raster_sync_locator.sv
bench/video_raster_sync_locator_tb.sv
